// ----- src/kmc_pkg.sv -----
// Shared constants for the 2-D k-means clustering block.
package kmc_pkg;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 8;
   localparam int K_CFG_BITS     = 5;
   localparam int ITER_BITS      = 8;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CLUSTER_COUNT  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_ITERATIONS = 8'd1;

   localparam logic [K_CFG_BITS-1:0] CLUSTER_COUNT_RESET  = 5'd16;
   localparam logic [ITER_BITS-1:0]  MAX_ITERATIONS_RESET = 8'd21;

   typedef logic [ITER_BITS-1:0] iter_type;

endpackage

// ----- src/kmc_ifaces.sv -----
// Valid/ready channel interfaces for points, results and register writes.
interface kmc_req_if #(parameter int COORD_BITS = 16) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;
   logic                  last_point;
   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface kmc_rsp_if #(parameter int COORD_BITS = 16, parameter int SIZE_BITS = 13) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] center_x;
   logic [COORD_BITS-1:0] center_y;
   logic [SIZE_BITS-1:0]  cluster_size;
   logic [7:0]            iteration_count;
   logic                  last_center;
   modport source (output valid, center_x, center_y, cluster_size, iteration_count,
                   last_center, input ready);
   modport sink   (input valid, center_x, center_y, cluster_size, iteration_count,
                   last_center, output ready);
endinterface

interface kmc_csr_if import kmc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/kmc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module kmc_div #(
   parameter int DW = 28,
   parameter int VW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic [VW:0]   rem_ff,  rem_in;
   logic [DW-1:0] quo_ff,  quo_in;
   logic [CW-1:0] cnt_ff,  cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;

   always_comb begin
      trial   = {rem_ff[VW-1:0], quo_ff[DW-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- src/kmeans_2d_clustering.sv -----
// Top level of the 2-D k-means clustering block (Lloyd passes over stored points).
//
// Points enter on req_ch, one per transfer, and are written to an on-chip point
// memory; the first points of a data set also seed the cluster centers. While the
// block is loading, req_ch.ready is high and a point is taken every cycle.
// A point with last_point set starts clustering and req_ch.ready drops until the
// last result has been transferred. Each pass fetches every point from the
// memory (one registered read), runs it through a three-stage distance pipeline
// against each center in turn, then adds it to its cluster's sums. After the
// points, each non-empty cluster divides its sums by its count in a shared
// bit-serial divider. Up to max_iterations passes run (one if it is zero); a
// pass in which no center changes ends the run early. Results then leave on
// rsp_ch, one center per transfer in index order; a stalled receiver simply
// holds the current result. Register writes on csr_ch are always taken and
// should be made while the block is idle. Reset is synchronous: it empties
// the data set, zeroes the centers and restores the register defaults; the
// point memory is not cleared.
module kmeans_2d_clustering
   import kmc_pkg::*;
#(
   parameter int MAX_POINTS   = 4096,
   parameter int MAX_CLUSTERS = 16,
   parameter int COORD_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   kmc_req_if.sink    req_ch,
   kmc_rsp_if.source  rsp_ch,
   kmc_csr_if.sink    csr_ch
);

   localparam int ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int TOTAL_W = $clog2(MAX_POINTS + 1);
   localparam int SUM_W   = COORD_BITS + TOTAL_W;
   localparam int CIDX_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int KW      = $clog2(MAX_CLUSTERS + 1);
   localparam int DIST_W  = 2 * COORD_BITS + 1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLEAR  = 4'd1;
   localparam logic [3:0] S_FETCH  = 4'd2;
   localparam logic [3:0] S_DIST   = 4'd3;
   localparam logic [3:0] S_ACCUM  = 4'd4;
   localparam logic [3:0] S_UPD    = 4'd5;
   localparam logic [3:0] S_WAIT_X = 4'd6;
   localparam logic [3:0] S_WAIT_Y = 4'd7;
   localparam logic [3:0] S_NEXT   = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   // Configuration registers.
   logic [K_CFG_BITS-1:0] cfg_k_ff;
   iter_type              cfg_iter_ff;

   // Control state.
   logic [3:0]         state_ff,  state_in;
   logic [TOTAL_W-1:0] total_ff,  total_in;
   logic [TOTAL_W-1:0] pidx_ff,   pidx_in;
   logic [KW-1:0]      k_ff,      k_in;
   iter_type           limit_ff,  limit_in;
   iter_type           pass_ff,   pass_in;
   logic [KW-1:0]      issue_ff,  issue_in;
   logic [CIDX_W-1:0]  j_ff,      j_in;
   logic [CIDX_W-1:0]  best_ff,   best_in;
   logic [DIST_W-1:0]  bestd_ff,  bestd_in;
   logic               same_ff,   same_in;
   logic               s1_vld_ff, s2_vld_ff;

   // Distance pipeline payload.
   logic [CIDX_W-1:0]       s1_idx_ff, s2_idx_ff;
   logic [COORD_BITS-1:0]   dx_ff, dy_ff;
   logic [2*COORD_BITS-1:0] sqx_ff, sqy_ff;
   logic [COORD_BITS-1:0]   qx_ff;

   // Cluster state.
   logic [COORD_BITS-1:0] cx_ff [MAX_CLUSTERS];
   logic [COORD_BITS-1:0] cy_ff [MAX_CLUSTERS];
   logic [SUM_W-1:0]      sx_ff [MAX_CLUSTERS];
   logic [SUM_W-1:0]      sy_ff [MAX_CLUSTERS];
   logic [TOTAL_W-1:0]    cnt_ff [MAX_CLUSTERS];

   // Point memory.
   logic [2*COORD_BITS-1:0] point_mem [MAX_POINTS];
   logic [2*COORD_BITS-1:0] mem_rd_ff;
   logic                    mem_we, mem_re;

   logic                    in_xfer, csr_xfer, out_xfer;
   logic [COORD_BITS-1:0]   px, py, ccx, ccy;
   logic [DIST_W-1:0]       sq_dist;
   logic                    issue_act;
   logic                    div_start, div_done;
   logic [SUM_W-1:0]        div_dividend, div_quot;
   logic [COORD_BITS-1:0]   div_q;
   logic [CIDX_W-1:0]       seed_idx;
   logic [CIDX_W-1:0]       issue_idx;
   logic                    j_last;
   int unsigned             k_clamp;

   assign in_xfer  = req_ch.valid && req_ch.ready;
   assign csr_xfer = csr_ch.valid && csr_ch.ready;
   assign out_xfer = rsp_ch.valid && rsp_ch.ready;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign px        = mem_rd_ff[2*COORD_BITS-1:COORD_BITS];
   assign py        = mem_rd_ff[COORD_BITS-1:0];
   assign issue_idx = CIDX_W'(issue_ff);
   assign ccx       = cx_ff[issue_idx];
   assign ccy       = cy_ff[issue_idx];
   assign issue_act = (state_ff == S_DIST) && (issue_ff < k_ff);
   assign sq_dist   = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   assign seed_idx  = CIDX_W'(total_ff);
   assign j_last    = (KW'(j_ff) == k_ff - 1'b1);
   assign div_q     = div_quot[COORD_BITS-1:0];

   always_comb begin
      if (cfg_k_ff == '0) begin
         k_clamp = 1;
      end else if (int'(cfg_k_ff) > MAX_CLUSTERS) begin
         k_clamp = MAX_CLUSTERS;
      end else begin
         k_clamp = int'(cfg_k_ff);
      end
   end

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_k_ff    <= CLUSTER_COUNT_RESET;
         cfg_iter_ff <= MAX_ITERATIONS_RESET;
      end else if (csr_xfer) begin
         case (csr_ch.index)
            REG_CLUSTER_COUNT:  cfg_k_ff    <= csr_ch.data[K_CFG_BITS-1:0];
            REG_MAX_ITERATIONS: cfg_iter_ff <= csr_ch.data[ITER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Point memory: one write port for loading, one registered read port for passes.
   assign mem_we = in_xfer && (total_ff < TOTAL_W'(MAX_POINTS));
   assign mem_re = (state_ff == S_FETCH);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[ADDR_W'(total_ff)] <= {req_ch.point_x, req_ch.point_y};
      end
      if (mem_re) begin
         mem_rd_ff <= point_mem[ADDR_W'(pidx_ff)];
      end
   end

   // The two coordinates of a cluster share the divider, x first.
   assign div_dividend = (state_ff == S_UPD) ? sx_ff[j_ff] : sy_ff[j_ff];
   assign div_start    = ((state_ff == S_UPD) && (cnt_ff[j_ff] != '0)) ||
                         ((state_ff == S_WAIT_X) && div_done);

   kmc_div #(
      .DW (SUM_W),
      .VW (TOTAL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_ff[j_ff]),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Main sequencer.
   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      pidx_in  = pidx_ff;
      k_in     = k_ff;
      limit_in = limit_ff;
      pass_in  = pass_ff;
      issue_in = issue_ff;
      j_in     = j_ff;
      best_in  = best_ff;
      bestd_in = bestd_ff;
      same_in  = same_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_xfer) begin
               if (total_ff < TOTAL_W'(MAX_POINTS)) begin
                  total_in = total_ff + 1'b1;
               end
               if (req_ch.last_point) begin
                  k_in     = KW'(k_clamp);
                  limit_in = (cfg_iter_ff == '0) ? iter_type'(1) : cfg_iter_ff;
                  pass_in  = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            pidx_in  = '0;
            same_in  = 1'b1;
            state_in = (total_ff == '0) ? S_UPD : S_FETCH;
            j_in     = '0;
         end
         S_FETCH: begin
            issue_in = '0;
            state_in = S_DIST;
         end
         S_DIST: begin
            if (issue_act) begin
               issue_in = issue_ff + 1'b1;
            end
            if (s2_vld_ff) begin
               if ((s2_idx_ff == '0) || (sq_dist < bestd_ff)) begin
                  best_in  = s2_idx_ff;
                  bestd_in = sq_dist;
               end
               if (KW'(s2_idx_ff) == k_ff - 1'b1) begin
                  state_in = S_ACCUM;
               end
            end
         end
         S_ACCUM: begin
            pidx_in = pidx_ff + 1'b1;
            if (pidx_ff + 1'b1 == total_ff) begin
               j_in     = '0;
               state_in = S_UPD;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_UPD: begin
            state_in = (cnt_ff[j_ff] != '0) ? S_WAIT_X : S_NEXT;
         end
         S_WAIT_X: begin
            if (div_done) begin
               state_in = S_WAIT_Y;
            end
         end
         S_WAIT_Y: begin
            if (div_done) begin
               if ((qx_ff != cx_ff[j_ff]) || (div_q != cy_ff[j_ff])) begin
                  same_in = 1'b0;
               end
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (j_last) begin
               pass_in = pass_ff + 1'b1;
               if (same_ff || (pass_ff + 1'b1 >= limit_ff)) begin
                  j_in     = '0;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_CLEAR;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_UPD;
            end
         end
         S_EMIT: begin
            if (out_xfer) begin
               if (j_last) begin
                  total_in = '0;
                  pass_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         total_ff  <= '0;
         pidx_ff   <= '0;
         k_ff      <= '0;
         limit_ff  <= '0;
         pass_ff   <= '0;
         issue_ff  <= '0;
         j_ff      <= '0;
         best_ff   <= '0;
         bestd_ff  <= '0;
         same_ff   <= 1'b1;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         total_ff  <= total_in;
         pidx_ff   <= pidx_in;
         k_ff      <= k_in;
         limit_ff  <= limit_in;
         pass_ff   <= pass_in;
         issue_ff  <= issue_in;
         j_ff      <= j_in;
         best_ff   <= best_in;
         bestd_ff  <= bestd_in;
         same_ff   <= same_in;
         s1_vld_ff <= issue_act;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // Distance pipeline: absolute differences, then squares, then sum and compare.
   always_ff @(posedge clock) begin
      s1_idx_ff <= issue_idx;
      dx_ff     <= (px > ccx) ? px - ccx : ccx - px;
      dy_ff     <= (py > ccy) ? py - ccy : ccy - py;
      s2_idx_ff <= s1_idx_ff;
      sqx_ff    <= dx_ff * dx_ff;
      sqy_ff    <= dy_ff * dy_ff;
      if ((state_ff == S_WAIT_X) && div_done) begin
         qx_ff <= div_q;
      end
   end

   // Centers: seeded while loading, rewritten after division, zeroed after a run.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CLUSTERS; i++) begin
            cx_ff[i] <= '0;
            cy_ff[i] <= '0;
         end
      end else if ((state_ff == S_EMIT) && out_xfer && j_last) begin
         for (int i = 0; i < MAX_CLUSTERS; i++) begin
            cx_ff[i] <= '0;
            cy_ff[i] <= '0;
         end
      end else if (in_xfer && (total_ff < TOTAL_W'(MAX_CLUSTERS))) begin
         cx_ff[seed_idx] <= req_ch.point_x;
         cy_ff[seed_idx] <= req_ch.point_y;
      end else if ((state_ff == S_WAIT_Y) && div_done) begin
         cx_ff[j_ff] <= qx_ff;
         cy_ff[j_ff] <= div_q;
      end
   end

   // Per-cluster sums and counts, cleared at the start of every pass.
   always_ff @(posedge clock) begin
      if (reset || (state_ff == S_CLEAR)) begin
         for (int i = 0; i < MAX_CLUSTERS; i++) begin
            sx_ff[i]  <= '0;
            sy_ff[i]  <= '0;
            cnt_ff[i] <= '0;
         end
      end else if (state_ff == S_ACCUM) begin
         sx_ff[best_ff]  <= sx_ff[best_ff] + SUM_W'(px);
         sy_ff[best_ff]  <= sy_ff[best_ff] + SUM_W'(py);
         cnt_ff[best_ff] <= cnt_ff[best_ff] + 1'b1;
      end
   end

   // Result channel reads the settled cluster state directly.
   assign rsp_ch.valid           = (state_ff == S_EMIT);
   assign rsp_ch.center_x        = cx_ff[j_ff];
   assign rsp_ch.center_y        = cy_ff[j_ff];
   assign rsp_ch.cluster_size    = cnt_ff[j_ff];
   assign rsp_ch.iteration_count = pass_ff - 1'b1;
   assign rsp_ch.last_center     = j_last;

endmodule

// ----- src/kmc_checker.sv -----
// Port-level checks for the k-means block, bound to the top level.
module kmc_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_last,
   input logic [COORD_BITS-1:0] rsp_center_x,
   input logic [7:0]            rsp_iter
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_center_x))
      else $error("result changed or dropped while stalled");

   a_busy_no_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("point accepted while results are pending");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("results continue after the final center");

   a_iter_constant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && $stable(rsp_iter))
      else $error("pass count differs between centers of one run");

endmodule

bind kmeans_2d_clustering kmc_checker #(.COORD_BITS(COORD_BITS)) u_kmc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_last     (rsp_ch.last_center),
   .rsp_center_x (rsp_ch.center_x),
   .rsp_iter     (rsp_ch.iteration_count)
);

// ----- test/kmc_tb_scoreboard.sv -----
`timescale 1ns / 1ps
// Scoreboard class that predicts k-means center results and checks them.
class kmc_center_scoreboard;
   typedef struct packed {
      logic [15:0] cx;
      logic [15:0] cy;
      logic [12:0] size;
      logic [7:0]  iters;
      logic        last;
   } center_result_t;

   logic [15:0] pts_x[$];
   logic [15:0] pts_y[$];
   logic [4:0]  k_reg;
   logic [7:0]  iter_reg;
   center_result_t pending[$];
   int mismatches;

   function new();
      k_reg = 5'd16;
      iter_reg = 8'd21;
      mismatches = 0;
   endfunction

   function void set_register(logic [7:0] idx, logic [7:0] value);
      if (idx == kmc_pkg::REG_CLUSTER_COUNT) k_reg = value[4:0];
      else if (idx == kmc_pkg::REG_MAX_ITERATIONS) iter_reg = value;
   endfunction

   // Stores the point; a last point runs the whole clustering and queues centers.
   function void note_point(logic [15:0] x, logic [15:0] y, logic last);
      int k, lim, passes, best, n;
      longint bd, d, dx, dy;
      longint sx[16], sy[16];
      int cnt[16];
      logic [15:0] cx[16], cy[16];
      bit same;
      center_result_t r;
      if (pts_x.size() < 4096) begin
         pts_x.push_back(x);
         pts_y.push_back(y);
      end
      if (!last) return;
      k = (k_reg == 0) ? 1 : (k_reg > 16 ? 16 : k_reg);
      lim = (iter_reg == 0) ? 1 : iter_reg;
      n = pts_x.size();
      for (int j = 0; j < 16; j++) begin
         cx[j] = (j < n) ? pts_x[j] : 16'd0;
         cy[j] = (j < n) ? pts_y[j] : 16'd0;
      end
      passes = 0;
      do begin
         same = 1;
         for (int j = 0; j < 16; j++) begin
            sx[j] = 0; sy[j] = 0; cnt[j] = 0;
         end
         for (int i = 0; i < n; i++) begin
            best = 0;
            bd = -1;
            for (int j = 0; j < k; j++) begin
               dx = longint'(cx[j]) - longint'(pts_x[i]);
               dy = longint'(cy[j]) - longint'(pts_y[i]);
               d = dx * dx + dy * dy;
               if (bd < 0 || d < bd) begin
                  bd = d; best = j;
               end
            end
            sx[best] += pts_x[i];
            sy[best] += pts_y[i];
            cnt[best]++;
         end
         for (int j = 0; j < k; j++) begin
            if (cnt[j] != 0) begin
               if (16'(sx[j] / cnt[j]) != cx[j] || 16'(sy[j] / cnt[j]) != cy[j]) same = 0;
               cx[j] = 16'(sx[j] / cnt[j]);
               cy[j] = 16'(sy[j] / cnt[j]);
            end
         end
         passes++;
      end while (!same && passes < lim);
      for (int j = 0; j < k; j++) begin
         r.cx = cx[j]; r.cy = cy[j]; r.size = 13'(cnt[j]);
         r.iters = 8'(passes - 1); r.last = (j == k - 1);
         pending.push_back(r);
      end
      pts_x.delete();
      pts_y.delete();
   endfunction

   function void check_center(center_result_t got);
      center_result_t want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected center transfer %h", got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("center mismatch: expected x=%h y=%h n=%0d it=%0d l=%b, got x=%h y=%h n=%0d it=%0d l=%b",
                     want.cx, want.cy, want.size, want.iters, want.last,
                     got.cx, got.cy, got.size, got.iters, got.last);
      end
   endfunction
endclass

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top-level testbench for the 2-D k-means clustering block.
module testbench;
   import kmc_pkg::*;

   logic clock = 0;
   logic reset = 1;
   always #1 clock = ~clock;

   kmc_req_if req_ch ();
   kmc_rsp_if rsp_ch ();
   kmc_csr_if csr_ch ();

   kmeans_2d_clustering u_top (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   kmc_center_scoreboard board = new();
   longint cycle_count = 0;
   // Generous: slowest correct runs are large sets times many passes.
   localparam longint CYCLE_LIMIT = 20_000_000;

   function automatic int random_gap();
      // Mostly no gap or a short one, occasionally a long one.
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      req_ch.valid = 0; req_ch.point_x = 0; req_ch.point_y = 0; req_ch.last_point = 0;
      csr_ch.valid = 0; csr_ch.index = 0; csr_ch.data = 0;
      rsp_ch.ready = 0;
   end

   // The receiver stalls at random; every accepted transfer is checked.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_center({rsp_ch.center_x, rsp_ch.center_y, rsp_ch.cluster_size,
                             rsp_ch.iteration_count, rsp_ch.last_center});
      rsp_ch.ready <= ($urandom_range(0, 99) < 70) || !$urandom_range(0, 3) && 1'b0 ||
                      (cycle_count[9:8] == 2'b00);
   end

   task automatic write_register(logic [7:0] idx, logic [7:0] value);
      csr_ch.valid <= 1; csr_ch.index <= idx; csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      board.set_register(idx, value);
      csr_ch.valid <= 0;
      @(posedge clock);
   endtask

   // Sends one point, with a random gap beforehand, and waits for its transfer.
   // Valid stays high between back-to-back points; drain_results drops it.
   task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
      int gap;
      gap = random_gap();
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.point_x <= x; req_ch.point_y <= y; req_ch.last_point <= last;
      do @(posedge clock); while (!req_ch.ready);
      board.note_point(x, y, last);
   endtask

   // Waits until every predicted center has been transferred, then lets the block settle.
   task automatic drain_results();
      req_ch.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_set(int n, bit clustered);
      logic [15:0] bx, by;
      for (int i = 0; i < n; i++) begin
         if (clustered && $urandom_range(0, 3) != 0) begin
            // Most points lie near one of 16 grid locations so that passes converge meaningfully.
            bx = 16'(($urandom_range(0, 3) * 16'h4000) + $urandom_range(0, 16'h0fff));
            by = 16'(($urandom_range(0, 3) * 16'h4000) + $urandom_range(0, 16'h0fff));
         end else begin
            bx = 16'($urandom); by = 16'($urandom);
         end
         send_point(bx, by, i == n - 1);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: extremes of coordinates with the reset setting, fewer points
      // than clusters, so unseeded centers stay at zero.
      send_point(16'h0000, 16'h0000, 0);
      send_point(16'hffff, 16'hffff, 0);
      send_point(16'hffff, 16'h0000, 0);
      send_point(16'h0000, 16'hffff, 1);
      drain_results();

      // One cluster, one point; then a tie between equidistant centers.
      write_register(REG_CLUSTER_COUNT, 8'd1);
      write_register(REG_MAX_ITERATIONS, 8'd1);
      send_point(16'h1234, 16'h5678, 1);
      drain_results();
      write_register(REG_CLUSTER_COUNT, 8'd2);
      write_register(REG_MAX_ITERATIONS, 8'd255);
      send_point(16'h0000, 16'h0000, 0);
      send_point(16'h0002, 16'h0000, 0);
      send_point(16'h0001, 16'h0000, 0);
      send_point(16'h0001, 16'h0000, 1);
      drain_results();

      // Out-of-range values: cluster count zero and above the maximum, limit zero.
      write_register(REG_CLUSTER_COUNT, 8'd0);
      write_register(REG_MAX_ITERATIONS, 8'd0);
      send_set(5, 0);
      drain_results();
      write_register(REG_CLUSTER_COUNT, 8'd31);
      send_set(6, 1);
      drain_results();
      write_register(8'd7, 8'd3);

      // Random part: several settings, clustered data with some noise.
      for (int s = 0; s < 8; s++) begin
         write_register(REG_CLUSTER_COUNT, 8'($urandom_range(1, 16)));
         write_register(REG_MAX_ITERATIONS,
                        (s == 0) ? 8'd255 : 8'($urandom_range(1, 30)));
         send_set($urandom_range(3, 12), $urandom_range(0, 3) != 0);
         drain_results();
      end
      write_register(REG_CLUSTER_COUNT, 8'd16);
      write_register(REG_MAX_ITERATIONS, 8'd21);
      send_set(20, 1);
      drain_results();

      repeat (50) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// ----- kmeans_2d_clustering.f -----
src/kmc_pkg.sv
src/kmc_ifaces.sv
src/kmc_div.sv
src/kmeans_2d_clustering.sv
src/kmc_checker.sv
test/kmc_tb_scoreboard.sv
test/testbench.sv
